>>> rtl/snd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_pkg
// Shared types, codes and helpers of the Sobel / NMS / threshold block.
// ----------------------------------------------------------------------------
package snd_pkg;

    localparam int CFG_BITS  = 11;
    localparam int LINE_BITS = 11;
    localparam int MAX_LINES = 1024;
    localparam int MAG_BITS  = 11;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HIGH_THR     = 2'd2;
    localparam logic [1:0] CFG_LOW_THR      = 2'd3;

    // direction sectors
    localparam logic [1:0] SEC_HORZ    = 2'd0;
    localparam logic [1:0] SEC_DIAG45  = 2'd1;
    localparam logic [1:0] SEC_VERT    = 2'd2;
    localparam logic [1:0] SEC_DIAG135 = 2'd3;

    // edge classes
    localparam logic [1:0] EDGE_NONE   = 2'd0;
    localparam logic [1:0] EDGE_WEAK   = 2'd1;
    localparam logic [1:0] EDGE_STRONG = 2'd2;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
        logic [CFG_BITS-1:0] high_thr;
        logic [CFG_BITS-1:0] low_thr;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRD0,
        ST_PRD1,
        ST_PWR,
        ST_GRAD,
        ST_SQR,
        ST_START,
        ST_ROOT,
        ST_ADV,
        ST_ERD,
        ST_ECTR,
        ST_EN1,
        ST_EN2,
        ST_EN3,
        ST_EOUT
    } t_state;

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

endpackage

>>> rtl/snd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_front
// Input side: accepts words, tags pixel or flush, queues them for the engine.
// ----------------------------------------------------------------------------
module snd_front #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [PIXEL_BITS-1:0] i_intensity,
    output logic                  o_q_valid,
    output logic                  o_q_flush,
    output logic [PIXEL_BITS-1:0] o_q_pixel,
    input  logic                  i_q_pop
);
    localparam int QD = 4;
    localparam int QA = $clog2(QD);

    logic [PIXEL_BITS:0] r_mem [QD];
    logic [QA-1:0]       r_wp;
    logic [QA-1:0]       r_rp;
    logic [QA:0]         r_cnt;
    logic                push;
    logic                pop;

    assign o_in_stall = (r_cnt == (QA+1)'(QD));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_flush  = r_mem[r_rp][PIXEL_BITS];
    assign o_q_pixel  = r_mem[r_rp][PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= {i_action, i_intensity};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/snd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_isqrt
// Floor square root, one result bit per cycle (digit recurrence).
// ----------------------------------------------------------------------------
module snd_isqrt #(
    parameter int RW = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_value,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    localparam int CNTW = $clog2(RW+1);

    logic [2*RW-1:0] r_val;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;

    assign rem_sh = {r_rem[RW-1:0], r_val[2*RW-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNTW'(RW);
        end else if (r_busy) begin
            r_val <= {r_val[2*RW-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1)) && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/snd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_engine
// Back end: line stores, Sobel window, magnitude/sector, suppression and
// thresholding, sequenced per queued word, with a registered result stage.
// ----------------------------------------------------------------------------
module snd_engine #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  snd_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  logic                          i_q_flush,
    input  logic [PIXEL_BITS-1:0]         i_q_pixel,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [snd_pkg::MAG_BITS-1:0]  o_gradient_magnitude,
    output logic [1:0]                    o_direction_sector,
    output logic                          o_local_maximum,
    output logic [1:0]                    o_edge_class,
    output logic                          o_end_of_frame
);
    localparam int XW  = $clog2(MAX_WIDTH+1);
    localparam int AW  = $clog2(3*MAX_WIDTH);
    localparam int GW  = PIXEL_BITS + 3;
    localparam int AB  = PIXEL_BITS + 2;
    localparam int RW  = PIXEL_BITS + 3;
    localparam int EW  = RW + 2;
    localparam int PW  = $clog2(2*MAX_WIDTH+3);
    localparam int CW2 = (RW > snd_pkg::MAG_BITS) ? RW : snd_pkg::MAG_BITS;
    localparam int LB  = snd_pkg::LINE_BITS;

    snd_pkg::t_state r_state, n_state;

    // geometry
    logic [XW-1:0] w;
    logic [LB-1:0] h;
    logic [PW-1:0] lag;

    always_comb begin
        if (i_cfg.width < 11'd3) begin
            w = XW'(3);
        end else if (int'(i_cfg.width) > MAX_WIDTH) begin
            w = XW'(MAX_WIDTH);
        end else begin
            w = XW'(i_cfg.width);
        end
        if (i_cfg.height < 11'd3) begin
            h = LB'(3);
        end else if (int'(i_cfg.height) > snd_pkg::MAX_LINES) begin
            h = LB'(snd_pkg::MAX_LINES);
        end else begin
            h = LB'(i_cfg.height);
        end
    end
    assign lag = PW'({w, 1'b0}) + PW'(2);

    // positions
    logic [XW-1:0] r_col, r_ocol;
    logic [LB-1:0] r_line, r_oline;
    logic [1:0]    r_lslot, r_oslot;
    logic [PW-1:0] r_pend;

    // item
    logic [PIXEL_BITS-1:0] r_pixel;

    // line stores
    logic [PIXEL_BITS-1:0] r_pix_mem [3*MAX_WIDTH];
    logic [EW-1:0]         r_mag_mem [3*MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_pix_rd;
    logic [EW-1:0]         r_mag_rd;
    logic [AW-1:0]         pix_addr, mag_addr;
    logic                  pix_we, mag_we;
    logic [EW-1:0]         mag_wdata;

    // window and gradient
    logic [PIXEL_BITS-1:0] r_win [9];
    logic [PIXEL_BITS-1:0] r_top;
    logic signed [GW-1:0]  q [9];
    logic signed [GW-1:0]  gx, gy;
    logic [AB-1:0]         r_a, r_b;
    logic                  r_same, r_zero;
    logic [2*AB-1:0]       r_aa, r_bb;
    logic [2*AB+1:0]       r_ss;
    logic [1:0]            r_sec, sector;
    logic                  sq_start, sq_done;
    logic [RW-1:0]         sq_root;

    // suppression
    logic [RW-1:0] r_m, r_m1, r_m2;
    logic [1:0]    r_s;
    logic          r_nbord;
    logic          xm, ym, yp;
    logic [XW-1:0] nx;
    logic [LB-1:0] ny;
    logic [1:0]    nslot;
    logic          n_bord, c_bord, eof, load;

    function automatic logic [AW-1:0] f_addr(input logic [1:0] slot,
                                             input logic [XW-1:0] col);
        logic [AW-1:0] base;
        case (slot)
            2'd1:    base = AW'(MAX_WIDTH);
            2'd2:    base = AW'(2*MAX_WIDTH);
            default: base = '0;
        endcase
        return base + AW'(col);
    endfunction

    function automatic logic f_border(input logic [XW-1:0] x, input logic [LB-1:0] y,
                                      input logic [XW-1:0] ww, input logic [LB-1:0] hh);
        return (x == '0) || (x >= ww - 1'b1) || (y == '0) || (y >= hh - 1'b1);
    endfunction

    // gradient
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            q[i] = GW'({1'b0, r_win[i]});
        end
        gx = q[2] - q[0] + (q[5] <<< 1) - (q[3] <<< 1) + q[8] - q[6];
        gy = q[6] + (q[7] <<< 1) + q[8] - q[0] - (q[1] <<< 1) - q[2];
    end

    always_comb begin
        if (r_zero) begin
            sector = snd_pkg::SEC_HORZ;
        end else if (r_ss < {1'b0, r_aa, 1'b0}) begin
            sector = snd_pkg::SEC_HORZ;
        end else if (r_ss < {1'b0, r_bb, 1'b0}) begin
            sector = snd_pkg::SEC_VERT;
        end else begin
            sector = r_same ? snd_pkg::SEC_DIAG45 : snd_pkg::SEC_DIAG135;
        end
    end

    snd_isqrt #(.RW(RW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value ((2*RW)'(r_aa) + (2*RW)'(r_bb)),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // neighbor along the sector; second neighbor is the mirror of the first
    always_comb begin
        logic xm1, ym1, yp1;
        case (r_s)
            snd_pkg::SEC_HORZ:   begin xm1 = 1'b1; ym1 = 1'b0; yp1 = 1'b0; end
            snd_pkg::SEC_DIAG45: begin xm1 = 1'b1; ym1 = 1'b1; yp1 = 1'b0; end
            snd_pkg::SEC_VERT:   begin xm1 = 1'b0; ym1 = 1'b1; yp1 = 1'b0; end
            default:             begin xm1 = 1'b1; ym1 = 1'b0; yp1 = 1'b1; end
        endcase
        xm = xm1;
        ym = ym1;
        yp = yp1;
        if (r_state == snd_pkg::ST_EN2) begin
            ym = yp1;
            yp = ym1;
        end
        if (r_state == snd_pkg::ST_EN2) begin
            nx = xm ? r_ocol + 1'b1 : r_ocol;
        end else begin
            nx = xm ? r_ocol - 1'b1 : r_ocol;
        end
        ny    = ym ? r_oline - 1'b1 : (yp ? r_oline + 1'b1 : r_oline);
        nslot = ym ? snd_pkg::slot_dec(r_oslot)
                   : (yp ? snd_pkg::slot_inc(r_oslot) : r_oslot);
    end

    assign n_bord = f_border(nx, ny, w, h);
    assign c_bord = f_border(r_ocol, r_oline, w, h);
    assign eof    = (r_ocol == w - 1'b1) && (r_oline == h - 1'b1);
    assign load   = (r_state == snd_pkg::ST_EOUT) && (!o_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            snd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_flush) begin
                        n_state = snd_pkg::ST_PRD0;
                    end else if (r_pend != '0) begin
                        n_state = snd_pkg::ST_ERD;
                    end
                end
            end
            snd_pkg::ST_PRD0: n_state = snd_pkg::ST_PRD1;
            snd_pkg::ST_PRD1: n_state = snd_pkg::ST_PWR;
            snd_pkg::ST_PWR: begin
                if (r_col >= XW'(2) && r_line >= LB'(2)) begin
                    n_state = snd_pkg::ST_GRAD;
                end else begin
                    n_state = snd_pkg::ST_ADV;
                end
            end
            snd_pkg::ST_GRAD:  n_state = snd_pkg::ST_SQR;
            snd_pkg::ST_SQR:   n_state = snd_pkg::ST_START;
            snd_pkg::ST_START: n_state = snd_pkg::ST_ROOT;
            snd_pkg::ST_ROOT: begin
                if (sq_done) begin
                    n_state = snd_pkg::ST_ADV;
                end
            end
            snd_pkg::ST_ADV: begin
                if (r_pend + 1'b1 > lag) begin
                    n_state = snd_pkg::ST_ERD;
                end else begin
                    n_state = snd_pkg::ST_IDLE;
                end
            end
            snd_pkg::ST_ERD:  n_state = c_bord ? snd_pkg::ST_EOUT : snd_pkg::ST_ECTR;
            snd_pkg::ST_ECTR: n_state = snd_pkg::ST_EN1;
            snd_pkg::ST_EN1:  n_state = snd_pkg::ST_EN2;
            snd_pkg::ST_EN2:  n_state = snd_pkg::ST_EN3;
            snd_pkg::ST_EN3:  n_state = snd_pkg::ST_EOUT;
            snd_pkg::ST_EOUT: begin
                if (load) begin
                    n_state = snd_pkg::ST_IDLE;
                end
            end
            default: n_state = snd_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop   = 1'b0;
        pix_we    = 1'b0;
        mag_we    = 1'b0;
        sq_start  = 1'b0;
        pix_addr  = f_addr(r_lslot, r_col);
        mag_addr  = f_addr(r_oslot, r_ocol);
        mag_wdata = {sq_root, r_sec};
        case (r_state)
            snd_pkg::ST_IDLE:  o_q_pop = i_q_valid;
            snd_pkg::ST_PRD0:  pix_addr = f_addr(snd_pkg::slot_inc(r_lslot), r_col);
            snd_pkg::ST_PRD1:  pix_addr = f_addr(snd_pkg::slot_dec(r_lslot), r_col);
            snd_pkg::ST_PWR:   pix_we = 1'b1;
            snd_pkg::ST_START: sq_start = 1'b1;
            snd_pkg::ST_ROOT: begin
                mag_addr = f_addr(snd_pkg::slot_dec(r_lslot), r_col - 1'b1);
                mag_we   = sq_done;
            end
            snd_pkg::ST_EN1:   mag_addr = f_addr(nslot, nx);
            snd_pkg::ST_EN2:   mag_addr = f_addr(nslot, nx);
            default: begin
            end
        endcase
    end

    // line stores
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_pix_mem[pix_addr] <= r_pixel;
        end
        r_pix_rd <= r_pix_mem[pix_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mag_we) begin
            r_mag_mem[mag_addr] <= mag_wdata;
        end
        r_mag_rd <= r_mag_mem[mag_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            snd_pkg::ST_IDLE: r_pixel <= i_q_pixel;
            snd_pkg::ST_PRD1: r_top <= r_pix_rd;
            snd_pkg::ST_PWR: begin
                r_win[0] <= r_win[1]; r_win[1] <= r_win[2]; r_win[2] <= r_top;
                r_win[3] <= r_win[4]; r_win[4] <= r_win[5]; r_win[5] <= r_pix_rd;
                r_win[6] <= r_win[7]; r_win[7] <= r_win[8]; r_win[8] <= r_pixel;
            end
            snd_pkg::ST_GRAD: begin
                r_a    <= AB'(gx < 0 ? -gx : gx);
                r_b    <= AB'(gy < 0 ? -gy : gy);
                r_same <= ((gx > 0) == (gy > 0));
                r_zero <= (gx == '0) && (gy == '0);
            end
            snd_pkg::ST_SQR: begin
                r_aa <= r_a * r_a;
                r_bb <= r_b * r_b;
                r_ss <= ((AB+1)'(r_a) + (AB+1)'(r_b)) * ((AB+1)'(r_a) + (AB+1)'(r_b));
            end
            snd_pkg::ST_START: r_sec <= sector;
            snd_pkg::ST_ECTR: begin
                r_m <= r_mag_rd[EW-1:2];
                r_s <= r_mag_rd[1:0];
            end
            snd_pkg::ST_EN1: r_nbord <= n_bord;
            snd_pkg::ST_EN2: begin
                r_m1    <= r_nbord ? '0 : r_mag_rd[EW-1:2];
                r_nbord <= n_bord;
            end
            snd_pkg::ST_EN3: r_m2 <= r_nbord ? '0 : r_mag_rd[EW-1:2];
            default: begin
            end
        endcase
    end

    // state, positions, pending count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snd_pkg::ST_IDLE;
            r_col   <= '0;
            r_line  <= '0;
            r_lslot <= '0;
            r_ocol  <= '0;
            r_oline <= '0;
            r_oslot <= '0;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == snd_pkg::ST_IDLE && i_q_valid) begin
                // positions outside a changed geometry restart
                if (r_col >= w) begin
                    r_col <= '0;
                end
                if (r_line >= h) begin
                    r_line  <= '0;
                    r_lslot <= '0;
                end
                if (r_ocol >= w) begin
                    r_ocol <= '0;
                end
                if (r_oline >= h) begin
                    r_oline <= '0;
                    r_oslot <= '0;
                end
                if (i_q_flush && r_pend != '0) begin
                    r_pend <= r_pend - 1'b1;
                end
            end
            if (r_state == snd_pkg::ST_ADV) begin
                if (r_col + 1'b1 >= w) begin
                    r_col <= '0;
                    if (r_line + 1'b1 >= h) begin
                        r_line  <= '0;
                        r_lslot <= '0;
                    end else begin
                        r_line  <= r_line + 1'b1;
                        r_lslot <= snd_pkg::slot_inc(r_lslot);
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
                r_pend <= (r_pend + 1'b1 > lag) ? lag : r_pend + 1'b1;
            end
            if (load) begin
                if (r_ocol + 1'b1 >= w) begin
                    r_ocol <= '0;
                    if (r_oline + 1'b1 >= h) begin
                        r_oline <= '0;
                        r_oslot <= '0;
                    end else begin
                        r_oline <= r_oline + 1'b1;
                        r_oslot <= snd_pkg::slot_inc(r_oslot);
                    end
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
        end
    end

    // result register
    logic [CW2-1:0] m_ext;
    assign m_ext = CW2'(r_m);

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_end_of_frame <= eof;
            if (c_bord) begin
                o_gradient_magnitude <= '0;
                o_direction_sector   <= snd_pkg::SEC_HORZ;
                o_local_maximum      <= 1'b0;
                o_edge_class         <= snd_pkg::EDGE_NONE;
            end else begin
                o_gradient_magnitude <= m_ext[snd_pkg::MAG_BITS-1:0];
                o_direction_sector   <= r_s;
                o_local_maximum      <= (r_m >= r_m1) && (r_m >= r_m2);
                if (m_ext > CW2'(i_cfg.high_thr)) begin
                    o_edge_class <= snd_pkg::EDGE_STRONG;
                end else if (m_ext > CW2'(i_cfg.low_thr)) begin
                    o_edge_class <= snd_pkg::EDGE_WEAK;
                end else begin
                    o_edge_class <= snd_pkg::EDGE_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/sobel_nms_double_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_nms_double_threshold
// Streaming Sobel magnitude/direction, non-maximum suppression and double
// threshold over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; one result word per pixel leaves in raster
// order, 2*W+2 pixels behind the input, and flush words drain the results
// still owed after the frame's last pixel. Words wait in a four-deep queue in
// front of a sequencer that owns single-port line stores for pixels and
// magnitudes. A pixel passes line-store reads and a write, and inside the
// frame also gradient work and the bit-serial square root; a result that
// is due adds the magnitude reads for suppression. Cost is set by the shared
// square-root unit and the one access per cycle on each line store. The line
// stores need no clearing after reset. The user must write configuration
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sobel_nms_double_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [snd_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [PIXEL_BITS-1:0]        i_intensity,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [snd_pkg::MAG_BITS-1:0] o_gradient_magnitude,
    output logic [1:0]                   o_direction_sector,
    output logic                         o_local_maximum,
    output logic [1:0]                   o_edge_class,
    output logic                         o_end_of_frame
);
    snd_pkg::t_cfg         r_cfg;
    logic                  q_valid, q_flush, q_pop;
    logic [PIXEL_BITS-1:0] q_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= 11'd600;
            r_cfg.height   <= 11'd600;
            r_cfg.high_thr <= 11'd160;
            r_cfg.low_thr  <= 11'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                snd_pkg::CFG_FRAME_WIDTH:  r_cfg.width    <= i_cfg_data;
                snd_pkg::CFG_FRAME_HEIGHT: r_cfg.height   <= i_cfg_data;
                snd_pkg::CFG_HIGH_THR:     r_cfg.high_thr <= i_cfg_data;
                snd_pkg::CFG_LOW_THR:      r_cfg.low_thr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    snd_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_intensity (i_intensity),
        .o_q_valid   (q_valid),
        .o_q_flush   (q_flush),
        .o_q_pixel   (q_pixel),
        .i_q_pop     (q_pop)
    );

    snd_engine #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_engine (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_q_valid            (q_valid),
        .i_q_flush            (q_flush),
        .i_q_pixel            (q_pixel),
        .o_q_pop              (q_pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_gradient_magnitude (o_gradient_magnitude),
        .o_direction_sector   (o_direction_sector),
        .o_local_maximum      (o_local_maximum),
        .o_edge_class         (o_edge_class),
        .o_end_of_frame       (o_end_of_frame)
    );

endmodule

>>> dv/sobel_nms_double_threshold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_nms_double_threshold_tb
// Streams small raster frames through the edge front end, predicts every
// result word with a local Sobel/NMS/threshold model and compares each field.
// ----------------------------------------------------------------------------
// A directed 3x3 frame with known results runs first. Random phases follow,
// each with its own geometry, thresholds and idling mix; a few phases use a
// geometry below the minimum. Frames run back to back and are drained by
// flush words only after a frame ends. Registers change only once all
// results are in.
// ----------------------------------------------------------------------------
module sobel_nms_double_threshold_tb;

    localparam int LINE_MAX    = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int QUIET       = 200;
    localparam int ITEM_TARGET = 800;

    typedef struct packed {
        logic [snd_pkg::MAG_BITS-1:0] mag;
        logic [1:0]                   sector;
        logic                         local_max;
        logic [1:0]                   cls;
        logic                         eof;
    } t_edge_word;

    typedef struct {
        bit          flush;
        logic [7:0]  pix;
        bit          has_res;
        t_edge_word  res;
    } t_table_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [1:0]                   i_cfg_index = snd_pkg::CFG_FRAME_WIDTH;
    logic [snd_pkg::CFG_BITS-1:0] i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_action = 1'b0;
    logic [7:0]                   i_intensity = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [snd_pkg::MAG_BITS-1:0] o_gradient_magnitude;
    logic [1:0]                   o_direction_sector;
    logic                         o_local_maximum;
    logic [1:0]                   o_edge_class;
    logic                         o_end_of_frame;

    sobel_nms_double_threshold DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // edge predictor
    // ------------------------------------------------------------------
    int unsigned width_reg, height_reg, high_reg, low_reg;
    int unsigned in_col, in_line, owed, res_col, res_line;
    int unsigned pix_store [3*LINE_MAX];
    int unsigned mag_store [3*LINE_MAX];   // magnitude*4 + sector

    function automatic int unsigned clamp_dim(int unsigned v);
        return (v < 3) ? 3 : (v > LINE_MAX) ? LINE_MAX : v;
    endfunction

    function automatic int unsigned floor_root(longint unsigned v);
        longint unsigned res = 0, b = 64'd1 << 40;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return int'(res);
    endfunction

    function automatic logic [1:0] sector_of(int gx, int gy);
        longint a = (gx < 0) ? -gx : gx;
        longint b = (gy < 0) ? -gy : gy;
        longint s = (a + b) * (a + b);
        if (a == 0 && b == 0) return snd_pkg::SEC_HORZ;
        if (s < 2 * a * a) return snd_pkg::SEC_HORZ;
        if (s < 2 * b * b) return snd_pkg::SEC_VERT;
        return ((gx > 0) == (gy > 0)) ? snd_pkg::SEC_DIAG45 : snd_pkg::SEC_DIAG135;
    endfunction

    function automatic bit is_border(int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h);
        return x == 0 || x >= w - 1 || y == 0 || y >= h - 1;
    endfunction

    function automatic int unsigned stored_mag(int unsigned x, int unsigned y,
                                               int unsigned w, int unsigned h);
        if (is_border(x, y, w, h)) return 0;
        return mag_store[(y % 3) * LINE_MAX + x];
    endfunction

    function automatic void sobel_at(int unsigned c, int unsigned l);
        int unsigned row_slot [3];
        int p [9];
        int gx, gy;
        int unsigned m;
        row_slot[0] = (l + 1) % 3;
        row_slot[1] = (l + 2) % 3;
        row_slot[2] = l % 3;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                p[r*3+k] = int'(pix_store[row_slot[r] * LINE_MAX + c - 2 + k]);
        gx = -p[0] + p[2] - 2*p[3] + 2*p[5] - p[6] + p[8];
        gy = -p[0] - 2*p[1] - p[2] + p[6] + 2*p[7] + p[8];
        m  = floor_root(longint'(gx) * gx + longint'(gy) * gy);
        mag_store[row_slot[1] * LINE_MAX + c - 1] = (m << 2) | 32'(sector_of(gx, gy));
    endfunction

    function automatic t_edge_word next_edge_word(int unsigned w, int unsigned h);
        t_edge_word r;
        int unsigned win [9];
        int unsigned m, n1, n2;
        logic [1:0] s;
        r = '0;
        r.eof = (res_col == w - 1 && res_line == h - 1);
        if (!is_border(res_col, res_line, w, h)) begin
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++)
                    win[y*3+x] = stored_mag(res_col - 1 + x, res_line - 1 + y, w, h);
            m = win[4] >> 2;
            s = win[4][1:0];
            case (s)
                snd_pkg::SEC_HORZ:   begin n1 = win[3]; n2 = win[5]; end
                snd_pkg::SEC_DIAG45: begin n1 = win[0]; n2 = win[8]; end
                snd_pkg::SEC_VERT:   begin n1 = win[1]; n2 = win[7]; end
                default:             begin n1 = win[6]; n2 = win[2]; end
            endcase
            r.mag       = m[snd_pkg::MAG_BITS-1:0];
            r.sector    = s;
            r.local_max = (m >= (n1 >> 2)) && (m >= (n2 >> 2));
            r.cls       = (m > high_reg) ? snd_pkg::EDGE_STRONG
                        : (m > low_reg)  ? snd_pkg::EDGE_WEAK : snd_pkg::EDGE_NONE;
        end
        if (++res_col >= w) begin
            res_col = 0;
            if (++res_line >= h) res_line = 0;
        end
        return r;
    endfunction

    function automatic bit edge_step(bit flush, logic [7:0] pix, output t_edge_word r);
        int unsigned w = clamp_dim(width_reg);
        int unsigned h = clamp_dim(height_reg);
        int unsigned lag = 2 * w + 2;
        r = '0;
        if (in_col >= w) in_col = 0;
        if (in_line >= h) in_line = 0;
        if (res_col >= w) res_col = 0;
        if (res_line >= h) res_line = 0;
        if (flush) begin
            if (owed == 0) return 0;
            r = next_edge_word(w, h);
            owed--;
            return 1;
        end
        pix_store[(in_line % 3) * LINE_MAX + in_col] = 32'(pix);
        if (in_col >= 2 && in_line >= 2) sobel_at(in_col, in_line);
        if (++in_col >= w) begin
            in_col = 0;
            if (++in_line >= h) in_line = 0;
        end
        owed++;
        if (owed > lag) begin
            r = next_edge_word(w, h);
            owed = lag;
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    t_edge_word expected_words [$];
    int         errors = 0;
    int         cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    task automatic report(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sobel_nms_double_threshold: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_edge_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report("unexpected word, magnitude", int'(o_gradient_magnitude), -1);
            end else begin
                e = expected_words.pop_front();
                if (o_gradient_magnitude !== e.mag)
                    report("magnitude", int'(o_gradient_magnitude), int'(e.mag));
                if (o_direction_sector !== e.sector)
                    report("sector", int'(o_direction_sector), int'(e.sector));
                if (o_local_maximum !== e.local_max)
                    report("local max", int'(o_local_maximum), int'(e.local_max));
                if (o_edge_class !== e.cls)
                    report("edge class", int'(o_edge_class), int'(e.cls));
                if (o_end_of_frame !== e.eof)
                    report("end of frame", int'(o_end_of_frame), int'(e.eof));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int items_sent = 0;

    // write enable drops for one cycle between writes
    task automatic write_reg(logic [1:0] idx, logic [snd_pkg::CFG_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            snd_pkg::CFG_FRAME_WIDTH:  width_reg  = 32'(val);
            snd_pkg::CFG_FRAME_HEIGHT: height_reg = 32'(val);
            snd_pkg::CFG_HIGH_THR:     high_reg   = 32'(val);
            default:                   low_reg    = 32'(val);
        endcase
        @(posedge i_clk);
    endtask

    // returns once the word is accepted; typed result overrides prediction
    task automatic send_word(bit flush, logic [7:0] pix, bit typed = 0,
                             bit typed_has = 0, t_edge_word typed_res = '0);
        t_edge_word r;
        bit fires;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= flush;
        i_intensity <= pix;
        do @(posedge i_clk); while (o_in_stall);
        fires = edge_step(flush, pix, r);
        if (typed) begin
            if (typed_has) expected_words.push_back(typed_res);
        end else if (fires) begin
            expected_words.push_back(r);
        end
        items_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (QUIET) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pattern_pix(int kind, int x, int y, int kx, int ky);
        int v;
        case (kind)
            0: return 8'($urandom);
            1: return ($urandom_range(1)) ? 8'd255 : 8'd0;
            default: begin
                v = 128 + kx * x + ky * y + int'($urandom_range(6)) - 3;
                return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
            end
        endcase
    endfunction

    t_table_row dir_rows [$];

    function automatic t_table_row mk_row(bit flush, logic [7:0] pix, bit has,
                                          t_edge_word res);
        t_table_row t;
        t.flush = flush; t.pix = pix; t.has_res = has; t.res = res;
        return t;
    endfunction

    initial begin
        t_edge_word z, center, last;
        int phase, kind, kx, ky, nframes, w, h;
        logic [snd_pkg::CFG_BITS-1:0] wv, hv;

        width_reg = 600; height_reg = 600; high_reg = 160; low_reg = 60;
        in_col = 0; in_line = 0; owed = 0; res_col = 0; res_line = 0;
        foreach (pix_store[i]) pix_store[i] = 0;
        foreach (mag_store[i]) mag_store[i] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame, right column bright: only the center is interior
        z = '0;
        center = '{mag: 11'd1020, sector: snd_pkg::SEC_HORZ, local_max: 1'b1,
                   cls: snd_pkg::EDGE_STRONG, eof: 1'b0};
        last = z;
        last.eof = 1'b1;
        dir_rows.push_back(mk_row(1, 8'd0, 0, z));     // flush with nothing owed
        for (int i = 0; i < 9; i++)
            dir_rows.push_back(mk_row(0, (i % 3 == 2) ? 8'd255 : 8'd0, i == 8, z));
        for (int i = 1; i < 9; i++)
            dir_rows.push_back(mk_row(1, 8'($urandom), 1,
                                      (i == 4) ? center : (i == 8) ? last : z));
        dir_rows.push_back(mk_row(1, 8'd0, 0, z));

        write_reg(snd_pkg::CFG_FRAME_WIDTH, 11'd3);
        write_reg(snd_pkg::CFG_FRAME_HEIGHT, 11'd3);
        foreach (dir_rows[i])
            send_word(dir_rows[i].flush, dir_rows[i].pix, 1,
                      dir_rows[i].has_res, dir_rows[i].res);
        drain();

        phase = 0;
        while (items_sent < ITEM_TARGET || phase < 8) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 61; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 61; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            nframes = int'($urandom_range(1, 3));
            case (phase)
                1: begin wv = 11'd0; hv = 11'd1; end  // clamps up to 3x3
                3: begin wv = 11'd3; hv = 11'd0; end
                default: begin
                    wv = 11'($urandom_range(3, 12));
                    hv = 11'($urandom_range(3, 9));
                end
            endcase
            write_reg(snd_pkg::CFG_FRAME_WIDTH, wv);
            write_reg(snd_pkg::CFG_FRAME_HEIGHT, hv);
            case ($urandom_range(4))
                0: write_reg(snd_pkg::CFG_HIGH_THR, 11'd0);
                1: write_reg(snd_pkg::CFG_HIGH_THR, 11'd2047);
                default: write_reg(snd_pkg::CFG_HIGH_THR, 11'($urandom_range(100, 1443)));
            endcase
            case ($urandom_range(4))
                0: write_reg(snd_pkg::CFG_LOW_THR, 11'd0);
                1: write_reg(snd_pkg::CFG_LOW_THR, 11'd1443);
                default: write_reg(snd_pkg::CFG_LOW_THR, 11'($urandom_range(0, 400)));
            endcase
            w = int'(clamp_dim(32'(wv)));
            h = int'(clamp_dim(32'(hv)));
            kind = int'($urandom_range(2));
            kx = int'($urandom_range(80)) - 40;
            ky = int'($urandom_range(80)) - 40;
            for (int f = 0; f < nframes; f++)
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                        send_word(0, pattern_pix(kind, x, y, kx, ky));
            for (int i = 0; i < 2 * w + 2 + int'($urandom_range(2)); i++)
                send_word(1, 8'($urandom));
            drain();
            phase++;
        end

        if (errors == 0) begin
            $display("sobel_nms_double_threshold: match");
        end else begin
            $display("sobel_nms_double_threshold: mismatch");
        end
        $finish;
    end

endmodule
